// ===== design/fsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_pkg
// Shared types and constants for the single-precision square root unit.
// ----------------------------------------------------------------------------
package fsq_pkg;

  localparam logic [31:0] EXP_MASK    = 32'h7f80_0000;
  localparam logic [31:0] FRAC_MASK   = 32'h007f_ffff;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'h7fc0_0000;
  localparam logic [31:0] HALF_EXP    = 32'h3f00_0000;
  localparam logic [31:0] EXP_OFFSET  = 32'h4000_0000;

  localparam int unsigned ROOT_BITS = 25;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned REM_W     = 32;
  localparam int unsigned Q_W       = 26;

  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(ROOT_BITS - 1);

  localparam logic [1:0] RND_NEAREST = 2'd0;
  localparam logic [1:0] RND_TRUNC   = 2'd1;
  localparam logic [1:0] RND_UP      = 2'd2;
  localparam logic [1:0] RND_DOWN    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_ROOT,
    S_PACK,
    S_DONE
  } fsq_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } fsq_ctl_t;

endpackage

// ===== design/fsq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_if
// Valid/ready channels of the square root unit: operand, result, config.
// ----------------------------------------------------------------------------
interface fsq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_word;
  modport source (output valid, output operand_word, input ready);
  modport sink (input valid, input operand_word, output ready);
  modport monitor (input valid, input operand_word, input ready);
endinterface

interface fsq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] root_word;
  logic        invalid_flag;
  logic        inexact_flag;
  modport source (output valid, output root_word, output invalid_flag,
                  output inexact_flag, input ready);
  modport sink (input valid, input root_word, input invalid_flag,
                input inexact_flag, output ready);
  modport monitor (input valid, input root_word, input invalid_flag,
                   input inexact_flag, input ready);
endinterface

interface fsq_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] rounding_mode;
  modport source (output valid, output rounding_mode, input ready);
  modport sink (input valid, input rounding_mode, output ready);
  modport monitor (input valid, input rounding_mode, input ready);
endinterface

// ===== design/fsq_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_root
// Restoring bit-by-bit root datapath: one compare/subtract step per cycle.
// ----------------------------------------------------------------------------
module fsq_root import fsq_pkg::*; (
  input  logic                 clk,
  input  fsq_ctl_t             ctl,
  input  logic [ROOT_BITS-1:0] mant,
  input  logic [IDX_W-1:0]     idx,
  output logic [Q_W-1:0]       q,
  output logic                 inexact
);

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] s;
  logic [REM_W-1:0] bit_val;
  logic [REM_W-1:0] t;
  logic             take;

  assign bit_val = REM_W'(1) << idx;
  assign t       = s + bit_val;
  assign take    = (t <= rem);
  assign inexact = (rem != '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= REM_W'({mant, 1'b0});
      s   <= '0;
      q   <= '0;
    end else if (ctl.step) begin
      // accept the trial bit when it fits, then double the remainder
      if (take) begin
        s   <= t + bit_val;
        rem <= (rem - t) << 1;
        q   <= q | Q_W'(bit_val);
      end else begin
        rem <= rem << 1;
      end
    end
  end

endmodule

// ===== design/float32_square_root_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_square_root_unit
// IEEE-754 single-precision square root with selectable rounding.
// ----------------------------------------------------------------------------
// Usage:
//   operand: one 32-bit float per transfer; ready only while the unit is idle.
//   result : root_word plus invalid and inexact flags, held in an output
//            register until the receiver takes the transfer.
//   cfg    : rounding_mode (0 nearest even, 1 truncate, 2 up, 3 acts as
//            truncate); write it only while the unit is idle.
// Sequence: special cases (zero, infinity, NaN, negative) reach the output
//   in the cycle after the operand transfer. Finite positive operands pass
//   through normalization (one shift a cycle, shifting only for subnormals;
//   the last normalization step loads the root datapath), then 25 root
//   iterations on the shared compare/subtract unit and a pack state, after
//   which the result shows in the done state.
// Throughput: a new operand is accepted only in idle, after the result
//   transfer, so only one operand is in flight at a time.
// Reset: returns to idle, drops any pending result, rounding mode to 0.
// Stall: a stalled receiver holds the result; the unit waits.
// ----------------------------------------------------------------------------
module float32_square_root_unit import fsq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fsq_in_if.sink     operand,
  fsq_out_if.source  result,
  fsq_cfg_if.sink    cfg
);

  fsq_state_t state, state_next;
  fsq_ctl_t   ctl;

  logic [1:0]       mode;
  logic [23:0]      mant;
  logic [8:0]       e9;      // unbiased exponent + 256
  logic [IDX_W-1:0] idx;
  logic [31:0]      root_word;
  logic             invalid_flag;
  logic             inexact_flag;

  logic [Q_W-1:0]       q;
  logic                 inexact;
  logic [ROOT_BITS-1:0] core_mant;
  logic [Q_W-1:0]       q_rnd;
  logic [31:0]          packed_word;

  logic [31:0] x;
  logic        x_is_max_exp;
  logic        x_frac_nz;
  logic        x_is_zero;
  logic        x_special;

  assign x            = operand.operand_word;
  assign x_is_max_exp = ((x & EXP_MASK) == EXP_MASK);
  assign x_frac_nz    = ((x & FRAC_MASK) != '0);
  assign x_is_zero    = (x[30:0] == '0);
  assign x_special    = x_is_max_exp || x_is_zero || x[31];

  assign operand.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;

  assign result.valid        = (state == S_DONE);
  assign result.root_word    = root_word;
  assign result.invalid_flag = invalid_flag;
  assign result.inexact_flag = inexact_flag;

  // odd exponent doubles the mantissa
  assign core_mant = e9[0] ? {mant, 1'b0} : {1'b0, mant};

  fsq_root u_root (
    .clk     (clk),
    .ctl     (ctl),
    .mant    (core_mant),
    .idx     (idx),
    .q       (q),
    .inexact (inexact)
  );

  // rounding and packing
  always_comb begin
    q_rnd = q;
    if (inexact) begin
      case (mode)
        RND_NEAREST: q_rnd = q + Q_W'(q[0]);
        RND_UP:      q_rnd = q + Q_W'(2);
        default:     q_rnd = q;
      endcase
    end
    packed_word = 32'(q_rnd >> 1) + HALF_EXP + (32'(e9[8:1]) << 23) - EXP_OFFSET;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (operand.valid) state_next = x_special ? S_DONE : S_NORM;
      end
      S_NORM: begin
        if (mant[23]) state_next = S_ROOT;
      end
      S_ROOT: begin
        if (idx == '0) state_next = S_PACK;
      end
      S_PACK:  state_next = S_DONE;
      S_DONE: begin
        if (result.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ctl = '0;
    case (state)
      S_NORM:  ctl.load = mant[23];
      S_ROOT:  ctl.step = 1'b1;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= RND_NEAREST;
    end else begin
      state <= state_next;
      if (cfg.valid) mode <= cfg.rounding_mode;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (operand.valid) begin
          // capture; special cases resolve right away
          if (x_is_max_exp && x_frac_nz) begin
            root_word    <= x | QUIET_BIT;
            invalid_flag <= 1'b0;
          end else if (x_is_zero || (x_is_max_exp && !x[31])) begin
            root_word    <= x;
            invalid_flag <= 1'b0;
          end else begin
            root_word    <= DEFAULT_NAN;
            invalid_flag <= 1'b1;
          end
          inexact_flag <= 1'b0;
          if (x[30:23] == '0) begin
            mant <= {1'b0, x[22:0]};
            e9   <= 9'd130;
          end else begin
            mant <= {1'b1, x[22:0]};
            e9   <= 9'(x[30:23]) + 9'd129;
          end
        end
      end
      S_NORM: begin
        // shift until the hidden bit is set
        if (mant[23]) begin
          idx <= FIRST_IDX;
        end else begin
          mant <= mant << 1;
          e9   <= e9 - 9'd1;
        end
      end
      S_ROOT: begin
        if (idx != '0) idx <= idx - IDX_W'(1);
      end
      S_PACK: begin
        root_word    <= packed_word;
        invalid_flag <= 1'b0;
        inexact_flag <= inexact;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== dv/fsq_root_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_root_checker
// Watches the operand, result and config channels of the square root unit,
// predicts each root and its flags, and compares in order.
// ----------------------------------------------------------------------------
module fsq_root_checker import fsq_pkg::*; (
  input  logic clk,
  input  logic rst,
  fsq_in_if.monitor  operand,
  fsq_out_if.monitor result,
  fsq_cfg_if.monitor cfg,
  output int      fail_count,
  output int      pending_roots
);

  typedef struct packed {
    logic [31:0] word;
    logic        invalid;
    logic        inexact;
  } root_t;

  root_t       expected_roots[$];
  logic [1:0]  round_mode;

  // Compute the root of one operand under the current rounding mode.
  function automatic root_t predict_root(logic [31:0] x, logic [1:0] mode);
    root_t r;
    logic [31:0] mant, rem, s, t, bit_w, q;
    int exp_b, unb, half;
    r = '0;
    if ((x & EXP_MASK) == EXP_MASK) begin
      if ((x & FRAC_MASK) != 0) r.word = x | QUIET_BIT;
      else if (!x[31]) r.word = x;
      else begin
        r.word = DEFAULT_NAN;
        r.invalid = 1'b1;
      end
      return r;
    end
    if (x[30:0] == 0) begin
      r.word = x;
      return r;
    end
    if (x[31]) begin
      r.word = DEFAULT_NAN;
      r.invalid = 1'b1;
      return r;
    end
    exp_b = int'(x[30:23]);
    mant = x;
    if (exp_b == 0) begin
      // Normalize the subnormal until the hidden bit shows.
      while (!mant[23]) begin
        mant = mant << 1;
        exp_b--;
      end
      exp_b++;
    end
    unb = exp_b - 127;
    mant = {8'd0, 1'b1, mant[22:0]};
    if (unb % 2 != 0) mant = mant << 1;
    half = ((unb + 256) >>> 1) - 128;
    rem = mant << 1;
    q = 0;
    s = 0;
    bit_w = 32'h0100_0000;
    while (bit_w != 0) begin
      t = s + bit_w;
      if (t <= rem) begin
        s = t + bit_w;
        rem = rem - t;
        q = q + bit_w;
      end
      rem = rem << 1;
      bit_w = bit_w >> 1;
    end
    r.inexact = (rem != 0);
    if (r.inexact) begin
      if (mode == RND_NEAREST) q = q + {31'd0, q[0]};
      else if (mode == RND_UP) q = q + 32'd2;
    end
    r.word = (q >> 1) + HALF_EXP + (32'(half + 128) << 23) - (32'd128 << 23);
    return r;
  endfunction

  assign pending_roots = expected_roots.size();

  always @(posedge clk) begin
    root_t want, got;
    if (rst) begin
      round_mode <= RND_NEAREST;
      fail_count <= 0;
      expected_roots.delete();
    end else begin
      if (cfg.valid && cfg.ready) round_mode <= cfg.rounding_mode;
      if (operand.valid && operand.ready)
        expected_roots.push_back(predict_root(operand.operand_word, round_mode));
      if (result.valid && result.ready) begin
        got = '{result.root_word, result.invalid_flag, result.inexact_flag};
        if (expected_roots.size() == 0) begin
          $display("%0t: unexpected result transfer %h/%b/%b", $time,
                   got.word, got.invalid, got.inexact);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_roots.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected %h inv %b inx %b actual %h inv %b inx %b",
                     $time, want.word, want.invalid, want.inexact,
                     got.word, got.invalid, got.inexact);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the square root unit with directed edge cases and random floats
// under every rounding mode, with bursty operands and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
  import fsq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_MODE = 240;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_roots;
  int   idle_cycles;
  bit   stall_en;

  fsq_in_if  operand();
  fsq_out_if result();
  fsq_cfg_if cfg();

  float32_square_root_unit uut (
    .clk(clk), .rst(rst), .operand(operand.sink), .result(result.source), .cfg(cfg.sink)
  );

  fsq_root_checker chk (
    .clk(clk), .rst(rst), .operand(operand.monitor), .result(result.monitor),
    .cfg(cfg.monitor), .fail_count(fail_count), .pending_roots(pending_roots)
  );

  always #2 clk = ~clk;

  // Receiver stall pattern: stretches of free flow alternate with random stalls.
  always @(negedge clk) begin
    if (rst) result.ready <= 1'b0;
    else if (!stall_en) result.ready <= 1'b1;
    else result.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(negedge clk) begin
    if (($time / 4000) % 2 == 0) stall_en <= 1'b0;
    else stall_en <= 1'b1;
  end

  // Watchdog: count cycles in which no transfer happens on any channel.
  always @(posedge clk) begin
    if (rst || (operand.valid && operand.ready) || (result.valid && result.ready)
        || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  int gap_left;
  int burst_left;

  // Send one operand; hold valid until the transfer, with bursty gaps.
  // Valid stays up after the transfer until the next call either drops it
  // for a gap or presents the next operand.
  task automatic send_operand(logic [31:0] w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
    end
    if (gap_left != 0) begin
      operand.valid <= 1'b0;
      repeat (gap_left) @(negedge clk);
    end
    gap_left = 0;
    burst_left--;
    operand.valid <= 1'b1;
    operand.operand_word <= w;
    do @(posedge clk); while (!operand.ready);
    @(negedge clk);
  endtask

  // Drain, then write the rounding mode while the unit is idle.
  task automatic set_mode(logic [1:0] m);
    operand.valid <= 1'b0;
    while (pending_roots != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.rounding_mode <= m;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w[30:23] = 8'h00;                         // subnormal or zero
      1: w[30:23] = 8'hff;                         // infinity or NaN
      2: w[22:0] = 23'($urandom_range(0, 3) << $urandom_range(0, 21));
      3: w[31] = 1'b1;
      default: w[31] = ($urandom_range(0, 7) == 0);
    endcase
    return w;
  endfunction

  logic [31:0] directed_ops[$] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
    32'h7fa0_0001, 32'hffc1_2345, 32'h7fff_ffff, 32'h8000_0001,
    32'hbf80_0000, 32'h0000_0001, 32'h007f_ffff, 32'h0040_0000,
    32'h0080_0000, 32'h7f7f_ffff, 32'h3f80_0000, 32'h4000_0000,
    32'h4080_0000, 32'h3f7f_ffff, 32'h4040_0000, 32'h3e80_0000,
    32'h0000_0003
  };

  initial begin
    logic [1:0] modes[5];
    operand.valid = 1'b0;
    operand.operand_word = '0;
    cfg.valid = 1'b0;
    cfg.rounding_mode = RND_NEAREST;
    burst_left = 0;
    gap_left = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed cases at the reset mode.
    foreach (directed_ops[i]) send_operand(directed_ops[i]);

    // Walk every mode, including the one that acts as truncate.
    modes = '{RND_TRUNC, RND_UP, RND_DOWN, RND_NEAREST, RND_UP};
    foreach (modes[m]) begin
      set_mode(modes[m]);
      if (m == 0) foreach (directed_ops[i]) send_operand(directed_ops[i]);
      for (int n = 0; n < RANDOM_PER_MODE * 4 / 5; n++) send_operand(random_float());
    end

    operand.valid <= 1'b0;
    while (pending_roots != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
